// ----- rtl/rdd_pkg.sv -----
package rdd_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DIGIT_DEPTH_DEF = 32;

    localparam int IN_W     = 32;
    localparam int RADIX_W  = 4;
    localparam int DIGIT_W  = 4;
    localparam int RESULT_W = 64;
    localparam int COUNT_W  = 6;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_RD_TOP,
        ST_POP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_mul;
        logic div_fix;
        logic rd_top;
        logic pop;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic stack_full;
        logic cnt_zero;
        logic pop_last;
        logic out_hold;
    } stat_t;

endpackage

// ----- rtl/rdd_ctrl.sv -----
module rdd_ctrl
    import rdd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output logic  in_stall,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV_MUL;
                end
            end
            ST_DIV_MUL:
            begin
                if (stat.mag_zero || stat.stack_full)
                begin
                    state_next = stat.cnt_zero ? ST_FINISH : ST_RD_TOP;
                end
                else
                begin
                    state_next = ST_DIV_FIX;
                end
            end
            ST_DIV_FIX:
            begin
                state_next = ST_DIV_MUL;
            end
            ST_RD_TOP:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (stat.pop_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DIV_MUL:
            begin
                cmd.div_mul = !(stat.mag_zero || stat.stack_full);
            end
            ST_DIV_FIX:
            begin
                cmd.div_fix = 1'b1;
            end
            ST_RD_TOP:
            begin
                cmd.rd_top = 1'b1;
            end
            ST_POP:
            begin
                cmd.pop = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !stat.out_hold;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/rdd_dpath.sv -----
module rdd_dpath
    import rdd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    input  logic [IN_W-1:0]            value_in,
    input  logic                       cfg_we,
    input  logic [RADIX_W-1:0]         cfg_wdata,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic signed [RESULT_W-1:0] decimal_spelled,
    output logic [COUNT_W-1:0]         digit_count,
    output logic                       overflow
);

    localparam int IW    = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
    localparam int CW    = $clog2(DIGIT_DEPTH + 1);
    localparam int REM_W = RADIX_W + 1;
    localparam int QD_W  = VALUE_WIDTH + RADIX_W;
    localparam int ACC_W = RESULT_W + 4;

    // floor(2^VALUE_WIDTH / d): the quotient estimate is low by at most one
    localparam logic [63:0] SCALE = 64'd1 << VALUE_WIDTH;
    localparam logic [VALUE_WIDTH-1:0] RECIP_2 = VALUE_WIDTH'(SCALE / 64'd2);
    localparam logic [VALUE_WIDTH-1:0] RECIP_3 = VALUE_WIDTH'(SCALE / 64'd3);
    localparam logic [VALUE_WIDTH-1:0] RECIP_4 = VALUE_WIDTH'(SCALE / 64'd4);
    localparam logic [VALUE_WIDTH-1:0] RECIP_5 = VALUE_WIDTH'(SCALE / 64'd5);
    localparam logic [VALUE_WIDTH-1:0] RECIP_6 = VALUE_WIDTH'(SCALE / 64'd6);
    localparam logic [VALUE_WIDTH-1:0] RECIP_7 = VALUE_WIDTH'(SCALE / 64'd7);
    localparam logic [VALUE_WIDTH-1:0] RECIP_8 = VALUE_WIDTH'(SCALE / 64'd8);
    localparam logic [VALUE_WIDTH-1:0] RECIP_9 = VALUE_WIDTH'(SCALE / 64'd9);

    logic [DIGIT_W-1:0] stack_mem [DIGIT_DEPTH];

    logic [RADIX_W-1:0]     radix_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [CW-1:0]          cnt_reg;
    logic [IW-1:0]          pop_ptr_reg;
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic [RESULT_W-1:0]    acc_reg;
    logic                   big_reg;
    logic                   out_valid_reg;
    logic [RESULT_W-1:0]    out_dec_reg;
    logic [COUNT_W-1:0]     out_cnt_reg;
    logic                   out_ovf_reg;

    logic [RADIX_W-1:0]       base;
    logic [VALUE_WIDTH-1:0]   recip;
    logic [VALUE_WIDTH-1:0]   in_v;
    logic [VALUE_WIDTH-1:0]   in_mag;
    logic [2*VALUE_WIDTH-1:0] product;
    logic [QD_W-1:0]          qd;
    logic [REM_W-1:0]         rem_raw;
    logic                     rem_fix;
    logic [DIGIT_W-1:0]       digit;
    logic [VALUE_WIDTH-1:0]   quot;
    logic [ACC_W-1:0]         acc_ext;
    logic [ACC_W-1:0]         acc_mac;
    logic [IW-1:0]            rd_addr;
    logic                     acc_ovf;

    // out-of-range codes act as the nearest legal base
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            base = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            base = RADIX_MAX;
        end
        else
        begin
            base = radix_reg;
        end
    end

    always_comb
    begin
        case (base)
            4'd2:    recip = RECIP_2;
            4'd3:    recip = RECIP_3;
            4'd4:    recip = RECIP_4;
            4'd5:    recip = RECIP_5;
            4'd6:    recip = RECIP_6;
            4'd7:    recip = RECIP_7;
            4'd8:    recip = RECIP_8;
            4'd9:    recip = RECIP_9;
            default: recip = RECIP_2;
        endcase
    end

    assign in_v   = value_in[VALUE_WIDTH-1:0];
    assign in_mag = in_v[VALUE_WIDTH-1] ? (~in_v + 1'b1) : in_v;

    assign product = (2*VALUE_WIDTH)'(mag_reg) * (2*VALUE_WIDTH)'(recip);

    // remainder is below twice the base, so its low bits are enough
    assign qd      = QD_W'(quot_reg) * QD_W'(base);
    assign rem_raw = mag_reg[REM_W-1:0] - qd[REM_W-1:0];
    assign rem_fix = rem_raw >= {1'b0, base};
    assign digit   = rem_fix ? DIGIT_W'(rem_raw - {1'b0, base}) : DIGIT_W'(rem_raw);
    assign quot    = rem_fix ? (quot_reg + 1'b1) : quot_reg;

    // times ten as shift and add; the top bits catch unsigned wrap
    assign acc_ext = ACC_W'(acc_reg);
    assign acc_mac = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(rd_data_reg);

    assign rd_addr = cmd.rd_top ? IW'(cnt_reg - 1'b1) : (pop_ptr_reg - 1'b1);

    assign acc_ovf = big_reg || (neg_reg ? (acc_reg[RESULT_W-1] && |acc_reg[RESULT_W-2:0])
                                         : acc_reg[RESULT_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_fix)
        begin
            stack_mem[cnt_reg[IW-1:0]] <= digit;
        end
        if (cmd.rd_top || cmd.pop)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= in_mag;
            neg_reg <= in_v[VALUE_WIDTH-1];
            cnt_reg <= '0;
            acc_reg <= '0;
            big_reg <= 1'b0;
        end
        if (cmd.div_mul)
        begin
            quot_reg <= product[2*VALUE_WIDTH-1:VALUE_WIDTH];
        end
        if (cmd.div_fix)
        begin
            mag_reg <= quot;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.rd_top)
        begin
            pop_ptr_reg <= IW'(cnt_reg - 1'b1);
        end
        if (cmd.pop)
        begin
            acc_reg     <= acc_mac[RESULT_W-1:0];
            big_reg     <= big_reg || (|acc_mac[ACC_W-1:RESULT_W]);
            pop_ptr_reg <= pop_ptr_reg - 1'b1;
        end
        if (cmd.finish)
        begin
            out_dec_reg <= neg_reg ? (~acc_reg + 1'b1) : acc_reg;
            out_cnt_reg <= COUNT_W'(cnt_reg);
            out_ovf_reg <= acc_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.mag_zero   = mag_reg == '0;
    assign stat.stack_full = cnt_reg == CW'(DIGIT_DEPTH);
    assign stat.cnt_zero   = cnt_reg == '0;
    assign stat.pop_last   = pop_ptr_reg == '0;
    assign stat.out_hold   = out_valid_reg && out_stall;

    assign out_valid       = out_valid_reg;
    assign decimal_spelled = out_dec_reg;
    assign digit_count     = out_cnt_reg;
    assign overflow        = out_ovf_reg;

endmodule

// ----- rtl/radix_digits_to_decimal.sv -----
// Converts a signed integer to base 2..9 and returns a number whose decimal digits spell
// that representation (negated for a negative input), with the digit count and a flag for
// results outside the signed 64-bit range. One item is worked at a time: each digit
// is found by a registered reciprocal multiply, then a remainder correction and a push
// onto the digit stack; the digits are then read from the top of the stack, popped and
// accumulated times ten, and the result is loaded into the output register.
// The next item is taken while the previous result still waits in the output register.
// The radix register may be written only while no item is in flight.
module radix_digits_to_decimal
    import rdd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [RADIX_W-1:0]         cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [IN_W-1:0]     value_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [RESULT_W-1:0] decimal_spelled,
    output logic [COUNT_W-1:0]         digit_count,
    output logic                       overflow
);

    cmd_t  cmd;
    stat_t stat;

    rdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    rdd_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .value_in        (value_in),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .decimal_spelled (decimal_spelled),
        .digit_count     (digit_count),
        .overflow        (overflow)
    );

endmodule
